### src/acfa_pkg.sv
package acfa_pkg;

    localparam int ACFA_NUM_SLOTS   = 6;
    localparam int ACFA_COUNT_WIDTH = 16;

    localparam int CHAN_W     = 4;
    localparam int SAMPLE_W   = 12;
    localparam int AVG_W      = 16;
    localparam int SLOT_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_SLOTS  = 8;

    // sum * 16 for 12.4 fixed point, one more bit for round-half-up
    localparam int FRAC_SHIFT = 5;

    localparam logic [CHAN_W-1:0] CHAN_RESET [MAX_SLOTS] = '{
        4'd6, 4'd4, 4'd0, 4'd3, 4'd7, 4'd5, 4'd0, 4'd0
    };

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] target;
    } t_route;

endpackage

### src/adc_channel_frame_averager_core.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_adc_channel, i_sample, i_frame_end
// output    out        o_out_valid / i_out_ready o_slot_index, o_average, o_last
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// A word without frame end is summed in the cycle it is accepted.
// A frame-end word then runs one shared restoring divider for each slot in turn,
// through the sequencer states and the output wait. Input is not ready meanwhile.
// Reset is synchronous, restores the channel map and zeros all sums and counts at once.
// A stalled result holds the sequencer; the next slot starts once it is taken.
module adc_channel_frame_averager_core #(
    parameter int NUM_SLOTS   = acfa_pkg::ACFA_NUM_SLOTS,
    parameter int COUNT_WIDTH = acfa_pkg::ACFA_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [acfa_pkg::CHAN_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [acfa_pkg::CHAN_W-1:0]     i_adc_channel,
    input  logic [acfa_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_frame_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [acfa_pkg::SLOT_IDX_W-1:0] o_slot_index,
    output logic [acfa_pkg::AVG_W-1:0]      o_average,
    output logic                            o_last
);
    import acfa_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUM_W  = SAMPLE_W + COUNT_WIDTH;
    localparam int NUM_W  = SUM_W + FRAC_SHIFT + 1;
    localparam int DEN_W  = COUNT_WIDTH + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_zero;
    logic                   r_out_valid;
    logic [AVG_W-1:0]       r_average;

    logic [SUM_W-1:0]       r_sum [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_SLOTS];

    t_route                 route;
    logic [SLOT_W-1:0]      tgt;
    logic                   in_xact;
    logic                   acc_en;
    logic [SUM_W-1:0]       sum_rd;
    logic [COUNT_WIDTH-1:0] cnt_rd;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [NUM_W-1:0]       div_quot;
    logic                   slot_last;

    acfa_slot_map #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_adc_channel(i_adc_channel),
        .o_route      (route)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xact    = i_in_valid && o_in_ready;
    assign tgt        = route.target[SLOT_W-1:0];
    assign acc_en     = in_xact && route.hit && (i_sample != '0) && (r_cnt[tgt] != '1);

    // one read address: the sequencer slot while dividing
    assign sum_rd    = r_sum[r_slot];
    assign cnt_rd    = r_cnt[r_slot];
    assign div_start = (r_state == S_START);
    assign div_num   = NUM_W'({sum_rd, FRAC_SHIFT'(0)}) + NUM_W'(cnt_rd);
    assign div_den   = {cnt_rd, 1'b0};
    assign slot_last = (r_slot == SLOT_W'(NUM_SLOTS - 1));

    acfa_divider #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_sum[s] <= '0;
                r_cnt[s] <= '0;
            end
        end else if (acc_en) begin
            r_sum[tgt] <= r_sum[tgt] + SUM_W'(i_sample);
            r_cnt[tgt] <= r_cnt[tgt] + COUNT_WIDTH'(1);
        end else if (div_start) begin
            // divider has latched the slot: clear it for the next frame
            r_sum[r_slot] <= '0;
            r_cnt[r_slot] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
            r_average   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact && i_frame_end) begin
                        r_slot  <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_zero  <= (cnt_rd == '0);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_average   <= r_zero ? '0 : div_quot[AVG_W-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (slot_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_state <= S_START;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = SLOT_IDX_W'(r_slot);
    assign o_average    = r_average;
    assign o_last       = slot_last;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("input not ready after the final result of a frame");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && i_frame_end) |=> (div_start && (r_slot == '0)))
        else $error("frame end did not start the first slot");
`endif

endmodule

### src/acfa_slot_map.sv
module acfa_slot_map #(
    parameter int NUM_SLOTS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [acfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [acfa_pkg::CHAN_W-1:0]    i_cfg_data,
    input  logic [acfa_pkg::CHAN_W-1:0]    i_adc_channel,
    output acfa_pkg::t_route               o_route
);
    import acfa_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [CHAN_W-1:0] r_chan [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_chan[s] <= CHAN_RESET[s];
            end
        end else if (i_cfg_we && (32'(i_cfg_idx) < NUM_SLOTS)) begin
            r_chan[i_cfg_idx[SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    // later slots override earlier ones: the highest match wins
    always_comb begin
        o_route = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (r_chan[s] == i_adc_channel) begin
                o_route.hit    = 1'b1;
                o_route.target = SLOT_IDX_W'(s);
            end
        end
    end

endmodule

### src/acfa_divider.sv
module acfa_divider #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(NUM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### dv/testbench.sv
module testbench;
    import acfa_pkg::*;

    localparam int NUM = ACFA_NUM_SLOTS;
    localparam int SUM_W = SAMPLE_W + ACFA_COUNT_WIDTH;
    localparam logic [ACFA_COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam int IDLE_PCT = 19;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] sample;
        logic                frame_end;
    } scan_word_t;

    typedef struct {
        logic [SLOT_IDX_W-1:0] slot;
        logic [AVG_W-1:0]      avg;
        logic                  last;
    } slot_avg_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CHAN_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic [CHAN_W-1:0] adc_channel = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic frame_end = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [AVG_W-1:0] average;
    logic last;

    // scan words waiting to be offered, and averages the block still owes
    scan_word_t pending_words[$];
    slot_avg_t expected_averages[$];

    // predictor state
    logic [CHAN_W-1:0] chan_map [NUM];
    logic [SUM_W-1:0] slot_sum [NUM];
    logic [ACFA_COUNT_WIDTH-1:0] slot_count [NUM];

    logic in_fire = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int words_taken = 0;
    int frames_done = 0;
    int averages_checked = 0;
    scan_word_t next_word;
    slot_avg_t want;

    adc_channel_frame_averager_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_adc_channel (adc_channel),
        .i_sample      (sample),
        .i_frame_end   (frame_end),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_slot_index  (slot_index),
        .o_average     (average),
        .o_last        (last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Route one scan word into the slot sums; on frame end, emit the averages and clear.
    task automatic absorb_word(input scan_word_t w);
        bit hit;
        int target;
        logic [63:0] num;
        logic [63:0] den;
        slot_avg_t r;
        hit = 1'b0;
        target = 0;
        for (int s = 0; s < NUM; s++) begin
            if (chan_map[s] == w.chan) begin
                hit = 1'b1;
                target = s;
            end
        end
        if (hit && w.sample != 0 && slot_count[target] != COUNT_MAX) begin
            slot_sum[target] += SUM_W'(w.sample);
            slot_count[target] += 1'b1;
        end
        if (w.frame_end) begin
            frames_done++;
            for (int s = 0; s < NUM; s++) begin
                r.slot = SLOT_IDX_W'(s);
                r.last = (s == NUM - 1);
                if (slot_count[s] == 0) begin
                    r.avg = '0;
                end else begin
                    // round half up: (sum*32 + n) / (2n)
                    num = (64'(slot_sum[s]) << FRAC_SHIFT) + 64'(slot_count[s]);
                    den = 64'(slot_count[s]) << 1;
                    r.avg = AVG_W'(num / den);
                end
                expected_averages.push_back(r);
                slot_sum[s] = '0;
                slot_count[s] = '0;
            end
        end
    endtask

    task automatic send(input int ch, input int smp, input bit fe);
        scan_word_t w;
        w.chan = CHAN_W'(ch);
        w.sample = SAMPLE_W'(smp);
        w.frame_end = fe;
        pending_words.push_back(w);
    endtask

    function automatic scan_word_t random_word();
        scan_word_t w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            w.chan = chan_map[$urandom_range(NUM - 1)];
        end else begin
            w.chan = CHAN_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            w.sample = '0;
        end else if (pick < 20) begin
            w.sample = SAMPLE_MAX;
        end else begin
            w.sample = SAMPLE_W'($urandom_range(SAMPLE_MAX, 1));
        end
        w.frame_end = ($urandom_range(9) == 0);
        return w;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            pending_words.push_back(random_word());
        end
    endtask

    task automatic write_reg(input int idx, input int data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_IDX_W'(idx);
        cfg_data <= CHAN_W'(data);
        if (idx < NUM) begin
            chan_map[idx] = CHAN_W'(data);
        end
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every average has come back.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_averages.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                next_word = pending_words.pop_front();
                adc_channel <= next_word.chan;
                sample <= next_word.sample;
                frame_end <= next_word.frame_end;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            words_taken++;
            absorb_word('{chan: adc_channel, sample: sample, frame_end: frame_end});
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_averages.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: slot %0d average %0d last %0b",
                         $time, slot_index, average, last);
            end else begin
                want = expected_averages.pop_front();
                averages_checked++;
                if (slot_index !== want.slot) begin
                    errors++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                end
                if (average !== want.avg) begin
                    errors++;
                    $display("%0t: average of slot %0d expected %0d actual %0d",
                             $time, want.slot, want.avg, average);
                end
                if (last !== want.last) begin
                    errors++;
                    $display("%0t: last of slot %0d expected %0b actual %0b",
                             $time, want.slot, want.last, last);
                end
            end
        end
    end

    // watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < NUM; s++) begin
            chan_map[s] = CHAN_RESET[s];
            slot_sum[s] = '0;
            slot_count[s] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // default map: extremes, zero sample, unmapped channel, rounding
        send(6, 1, 0);
        send(4, 4095, 0);
        send(0, 0, 0);
        send(3, 2048, 0);
        send(7, 4095, 0);
        send(7, 1, 0);
        send(5, 3, 0);
        send(5, 4, 0);
        send(15, 4095, 0);
        send(0, 2, 1);
        send(9, 0, 1);
        send(5, 4095, 1);
        drain();

        // duplicate mappings at both channel extremes; out-of-range indexes are dropped
        write_reg(0, 15);
        write_reg(1, 0);
        write_reg(2, 15);
        write_reg(3, 0);
        write_reg(4, 9);
        write_reg(5, 9);
        write_reg(6, 3);
        write_reg(7, 3);
        end_writes();
        send(15, 100, 0);
        send(0, 4095, 0);
        send(9, 7, 0);
        send(9, 8, 0);
        send(6, 5, 0);
        send(15, 0, 1);
        send_random(50);
        drain();

        // random map, with a long output stall so the input backs up
        for (int s = 0; s < NUM; s++) begin
            write_reg(s, $urandom_range(15));
        end
        end_writes();
        hold_req = 1'b1;
        send_random(50);
        send(chan_map[0], 4095, 1);
        drain();

        // every slot on one channel: the top slot takes all, back to back
        for (int s = 0; s < NUM; s++) begin
            write_reg(s, 15);
        end
        end_writes();
        calm = 1'b1;
        send_random(40);
        send(15, 4095, 1);
        drain();
        calm = 1'b0;
        repeat (40) @(negedge clk);

        if (expected_averages.size() != 0) begin
            errors++;
            $display("%0t: %0d averages never arrived", $time, expected_averages.size());
        end
        $display("Run covered %0d frames, %0d averages checked, %0d scan words accepted;",
                 frames_done, averages_checked, words_taken);
        $display("maps with duplicates and unmapped channels, zero samples, a long stall.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### adc_channel_frame_averager_core.f
src/acfa_pkg.sv
src/acfa_slot_map.sv
src/acfa_divider.sv
src/adc_channel_frame_averager_core.sv
dv/testbench.sv
